// ===== hdl/kbl_pkg.sv =====
// shared types, constants and scan code tables for the keyboard line buffer
package kbl_pkg;

	localparam int LINE_DEPTH_DEF = 64;

	localparam logic [7:0] KEY_RELEASE  = 8'h80;
	localparam logic [7:0] KEY_MAX_CODE = 8'h3a;
	localparam logic [7:0] KEY_LSHIFT   = 8'h2a;
	localparam logic [7:0] KEY_RSHIFT   = 8'h36;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	localparam logic       CMD_SCAN = 1'b0;
	localparam logic       CMD_READ = 1'b1;

	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_LINE   = 2'd1;
	localparam logic [1:0] KIND_NOLINE = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [7:0] scan_code;
	} item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] out_kind;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] wr_char;
	} cell_ctrl_t;

	localparam logic [7:0] PLAIN_MAP [64] = '{
		8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] SHIFT_MAP [64] = '{
		8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
		8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	function automatic logic [7:0] map_char(input logic shifted, input logic [5:0] code);
		map_char = shifted ? SHIFT_MAP[code] : PLAIN_MAP[code];
	endfunction

endpackage

// ===== hdl/kbl_cell.sv =====
// one character cell of the line store row
module kbl_cell (
	input  logic                clk,
	input  kbl_pkg::cell_ctrl_t ctrl,
	input  logic                wr_sel,
	input  logic [7:0]          nxt_char,
	output logic [7:0]          cell_char
);
	import kbl_pkg::*;

	logic [7:0] char_q;

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			char_q <= ctrl.wr_char;
		end else if (ctrl.shift) begin
			char_q <= nxt_char;
		end
	end

	assign cell_char = char_q;

endmodule

// ===== hdl/keyboard_scancode_line_buffer.sv =====
// top level: scan code decode, line store cell row and read sequencer
// A scan code beat's echo, if any, goes to the result register in the same
// cycle that the beat is taken, and a new beat is taken only when that
// register is free or being emptied. A read request rotates the row of
// LINE_DEPTH cells once all the way round while cell 0 is checked for the
// first newline in the filled part, then either one no-line result follows
// or the line is shifted out of cell 0 at one character per cycle while the
// result side is not stalling. The cell row is the only store and needs no
// clearing after reset.
module keyboard_scancode_line_buffer #(
	parameter int LINE_DEPTH = kbl_pkg::LINE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  kbl_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output kbl_pkg::result_t result
);
	import kbl_pkg::*;

	localparam int IDX_W = $clog2(LINE_DEPTH);
	localparam int CNT_W = $clog2(LINE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_REPORT,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] len_q;
	logic [IDX_W-1:0] cnt_q;
	logic             found_q;
	logic             shift_held_q;
	logic             result_valid_q;
	result_t          result_q;

	logic [7:0]       cell_char [LINE_DEPTH];
	logic [7:0]       nxt_char  [LINE_DEPTH];
	logic [LINE_DEPTH-1:0] wr_sel;
	cell_ctrl_t       cell_ctrl;

	logic             slot_free;
	logic             accept;
	logic [7:0]       code;
	logic             is_break;
	logic             is_shift_make;
	logic [7:0]       key_char;
	logic             echo;
	logic             append;
	logic             emit_go;
	logic             load_result;
	logic             hit;
	logic             last_char;

	assign slot_free  = !result_valid_q || result_ready;
	assign item_ready = (state_q == ST_IDLE) && slot_free;
	assign accept     = item_valid && item_ready;

	assign code          = item.scan_code;
	assign is_break      = (code & KEY_RELEASE) != 8'h00;
	assign is_shift_make = (code == KEY_LSHIFT) || (code == KEY_RSHIFT);

	always_comb begin
		key_char = 8'h00;
		if (!is_break && !is_shift_make && code <= KEY_MAX_CODE) begin
			key_char = map_char(shift_held_q, code[5:0]);
		end
	end

	assign echo   = accept && (item.cmd == CMD_SCAN) && (key_char != 8'h00);
	assign append = echo && (key_char != CH_BACKSPACE) && (fill_q < CNT_W'(LINE_DEPTH));

	assign emit_go     = (state_q == ST_EMIT) && slot_free;
	assign load_result = echo || ((state_q == ST_REPORT) && slot_free) || emit_go;
	assign hit       = !found_q && (CNT_W'(cnt_q) < fill_q) && (cell_char[0] == CH_NEWLINE);
	assign last_char = (CNT_W'(cnt_q) + CNT_W'(1)) == len_q;

	assign cell_ctrl.shift   = (state_q == ST_SEARCH) || emit_go;
	assign cell_ctrl.wr_char = key_char;

	for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
		if (i == LINE_DEPTH - 1) begin : g_wrap
			assign nxt_char[i] = cell_char[0];
		end else begin : g_link
			assign nxt_char[i] = cell_char[i+1];
		end

		assign wr_sel[i] = append && (fill_q == CNT_W'(i));

		kbl_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.wr_sel    (wr_sel[i]),
			.nxt_char  (nxt_char[i]),
			.cell_char (cell_char[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fill_q         <= '0;
			len_q          <= '0;
			cnt_q          <= '0;
			found_q        <= 1'b0;
			shift_held_q   <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && !load_result) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_READ) begin
							state_q <= ST_SEARCH;
							cnt_q   <= '0;
							found_q <= 1'b0;
							len_q   <= '0;
						end else begin
							if (is_break) begin
								if (code == (KEY_LSHIFT | KEY_RELEASE) ||
								    code == (KEY_RSHIFT | KEY_RELEASE)) begin
									shift_held_q <= 1'b0;
								end
							end else if (is_shift_make) begin
								shift_held_q <= 1'b1;
							end
							if (echo) begin
								result_q       <= '{out_char: key_char, out_kind: KIND_ECHO,
								                    last: 1'b1};
								result_valid_q <= 1'b1;
								if (key_char == CH_BACKSPACE) begin
									if (fill_q != '0) begin
										fill_q <= fill_q - CNT_W'(1);
									end
								end else if (append) begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
						end
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
						len_q   <= CNT_W'(cnt_q) + CNT_W'(1);
					end
					if (cnt_q == IDX_W'(LINE_DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= (found_q || hit) ? ST_EMIT : ST_REPORT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_REPORT: begin
					if (slot_free) begin
						result_q       <= '{out_char: 8'h00, out_kind: KIND_NOLINE, last: 1'b1};
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						result_q       <= '{out_char: cell_char[0], out_kind: KIND_LINE,
						                    last: last_char};
						result_valid_q <= 1'b1;
						if (last_char) begin
							fill_q  <= fill_q - len_q;
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
